// ===== sv/cil_pkg.sv =====
// cil_pkg: types and constants of the interpolating colour map lookup.
// Used by colormap_interpolating_lookup; depends on nothing.
package cil_pkg;

	// Field widths fixed by the stream and register layout
	localparam int unsigned FIELD_W = 16;   // Q0.16 channel and scalar fields
	localparam int unsigned CNT_W   = 9;    // color_count register
	localparam int unsigned IDX_W   = 8;    // entry_index field
	localparam int unsigned NUM_W   = 25;   // alpha dividend
	localparam int unsigned REM_W   = 10;   // divider remainder
	localparam int unsigned DIST_W  = 10;   // |c - 2n|
	localparam int unsigned PADDR_W = 3;

	// Divider: one quotient bit per step, DIV_STEPS steps per stage
	localparam int unsigned DIV_STAGES = 5;
	localparam int unsigned DIV_STEPS  = 5;

	// Q0.16 constants: 0.10, 0.9, 0.45, 0.5
	localparam logic [15:0] Q_TENTH       = 16'd6554;
	localparam logic [15:0] Q_NINE_TENTHS = 16'd58982;
	localparam logic [15:0] Q_FORTY_FIVE  = 16'd29491;
	localparam logic [15:0] Q_HALF        = 16'd32768;

	// Item kinds carried in tuser
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	// Register word index (paddr[2])
	localparam logic REG_COLOR_COUNT  = 1'b0;
	localparam logic REG_OPACITY_MODE = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_RESET = 9'd256;

	typedef enum logic [1:0] {
		OPA_DESCEND = 2'd0,
		OPA_VSHAPE  = 2'd1,
		OPA_ASCEND  = 2'd2,
		OPA_HALF    = 2'd3
	} opacity_mode_t;

	typedef logic [FIELD_W-1:0] rgb_t [3];

	// One divider stage: colour rides along with the division in flight
	typedef struct packed {
		logic                   valid;
		logic                   zero;
		logic [3*FIELD_W-1:0]   rgb;
		logic [REM_W-1:0]       rem;
		logic [NUM_W-1:0]       nq;
	} div_stage_t;

endpackage

// ===== sv/colormap_interpolating_lookup.sv =====
// colormap_interpolating_lookup: colour table with linear interpolation and opacity ramp.
// Depends on cil_pkg (sv/cil_pkg.sv).
//
//  channel  | direction | carries
//  ---------+-----------+-----------------------------------------------------------
//  s_*      | in        | load (write table entry) or lookup (scalar) transaction
//  m_*      | out       | one colour/alpha transaction per lookup, none per load
//  APB p*   | in/out    | color_count at 0x0, opacity_mode at 0x4
//
// One transaction per clock in while no result is stalled; ten registers deep (s1..s4,
// DIV_STAGES, output) from the accepting edge to m_tvalid.
// The alpha divide fills the DIV_STAGES (one quotient bit per step, five steps per stage).
// Table memory: one write port, two registered read ports (entries n and n+1).
// Reset clears valid bits, configuration and divider stages; the table holds no reset value.
// m_tready low with a result waiting freezes every stage and drops s_tready.
module colormap_interpolating_lookup #(
	parameter int unsigned TABLE_DEPTH  = 256,
	parameter int unsigned CHANNEL_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// stream in
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [71:0]                  s_tdata,  // entry_index, red_in, green_in, blue_in, scalar_value
	input  logic                         s_tuser,  // mode
	// stream out
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [63:0]                  m_tdata,  // red_out, green_out, blue_out, alpha_out
	// APB configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cil_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CB   = CHANNEL_BITS;
	localparam int unsigned PW   = CB + cil_pkg::FIELD_W + 1;   // product width
	localparam int unsigned FW   = cil_pkg::FIELD_W;
	localparam int unsigned NW   = cil_pkg::NUM_W;
	localparam int unsigned RW   = cil_pkg::REM_W;
	localparam int unsigned CW   = cil_pkg::CNT_W;
	localparam int unsigned NDS  = cil_pkg::DIV_STAGES;
	localparam logic [CB-1:0] CH_ONES = {CB{1'b1}};

	// ---------------- configuration ----------------
	logic [CW-1:0]          color_count_q;
	cil_pkg::opacity_mode_t opacity_mode_q;
	logic                   cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_count_q  <= cil_pkg::COUNT_RESET;
			opacity_mode_q <= cil_pkg::OPA_ASCEND;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				cil_pkg::REG_COLOR_COUNT:  color_count_q  <= pwdata[CW-1:0];
				cil_pkg::REG_OPACITY_MODE: opacity_mode_q <= cil_pkg::opacity_mode_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			cil_pkg::REG_COLOR_COUNT:  prdata = 32'(color_count_q);
			cil_pkg::REG_OPACITY_MODE: prdata = 32'(opacity_mode_q);
			default:                   prdata = '0;
		endcase
	end

	// active count: 0 acts as 1, anything past the table acts as its depth
	logic [CW-1:0] cnt;
	always_comb begin
		if (color_count_q == '0)
			cnt = CW'(1);
		else if (32'(color_count_q) > TABLE_DEPTH)
			cnt = CW'(TABLE_DEPTH);
		else
			cnt = color_count_q;
	end

	// ---------------- handshake ----------------
	logic en, acc;
	logic out_valid_q;
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign acc      = s_tvalid && en;

	// input fields
	logic [cil_pkg::IDX_W-1:0] entry_index;
	logic [FW-1:0] red_in, green_in, blue_in, scalar_value;
	assign entry_index  = s_tdata[7:0];
	assign red_in       = s_tdata[23:8];
	assign green_in     = s_tdata[39:24];
	assign blue_in      = s_tdata[55:40];
	assign scalar_value = s_tdata[71:56];

	// ---------------- table ----------------
	logic [3*CB-1:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (acc && s_tuser == cil_pkg::MODE_LOAD && 32'(entry_index) < TABLE_DEPTH)
			mem[AW'(entry_index)] <= {CB'(blue_in), CB'(green_in), CB'(red_in)};
	end

	// ---------------- stage 1: index and fraction ----------------
	logic [CW+FW-1:0] p;
	logic [CW-1:0]    n_c, last_c;
	logic             last_c_hit;
	assign p          = (CW+FW)'(scalar_value) * (CW+FW)'(cnt);
	assign n_c        = p[CW+FW-1:FW];
	assign last_c     = cnt - CW'(1);
	assign last_c_hit = n_c >= last_c;

	logic           valid_s1, zero_s1;
	logic [CW-1:0]  n_s1;
	logic [FW-1:0]  f_s1;
	logic [AW-1:0]  addr_a_s1, addr_b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= acc && s_tuser == cil_pkg::MODE_LOOKUP;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1      <= n_c;
			zero_s1   <= n_c == '0;
			f_s1      <= last_c_hit ? '0 : p[FW-1:0];   // last entry: no blend
			addr_a_s1 <= last_c_hit ? AW'(last_c) : AW'(n_c);
			addr_b_s1 <= AW'(n_c + CW'(1));
		end
	end

	// ---------------- stage 2: table read, alpha dividend ----------------
	logic [CW:0]     two_n;
	logic [cil_pkg::DIST_W-1:0] span_c;
	logic [NW-1:0]   num_c;
	assign two_n  = {n_s1, 1'b0};
	assign span_c = ({1'b0, cnt} >= two_n) ? cil_pkg::DIST_W'({1'b0, cnt} - two_n)
	                                       : cil_pkg::DIST_W'(two_n - {1'b0, cnt});

	always_comb begin
		unique case (opacity_mode_q)
			cil_pkg::OPA_DESCEND: num_c = NW'(cil_pkg::Q_NINE_TENTHS) * NW'(cnt - n_s1);
			cil_pkg::OPA_VSHAPE:  num_c = NW'(cil_pkg::Q_FORTY_FIVE) * NW'(span_c);
			cil_pkg::OPA_ASCEND:  num_c = NW'(cil_pkg::Q_NINE_TENTHS) * NW'(n_s1);
			default:              num_c = '0;
		endcase
	end

	logic            valid_s2, zero_s2;
	logic [3*CB-1:0] rd_a_s2, rd_b_s2;
	logic [FW-1:0]   f_s2;
	logic [NW-1:0]   num_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_a_s2 <= mem[addr_a_s1];
			rd_b_s2 <= mem[addr_b_s1];
			zero_s2 <= zero_s1;
			f_s2    <= f_s1;
			num_s2  <= num_c + NW'(cnt >> 1);   // + c/2 rounds the quotient
		end
	end

	// ---------------- stage 3: blend products ----------------
	logic            valid_s3, zero_s3;
	logic [PW-1:0]   pa_s3 [3];
	logic [PW-1:0]   pb_s3 [3];
	logic [NW-1:0]   num_s3;
	logic [FW:0]     inv_f;
	assign inv_f = 17'h10000 - {1'b0, f_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (en)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa_s3[i] <= PW'(rd_a_s2[i*CB +: CB]) * PW'(inv_f);
				pb_s3[i] <= PW'(rd_b_s2[i*CB +: CB]) * PW'(f_s2);
			end
			zero_s3 <= zero_s2;
			num_s3  <= num_s2;
		end
	end

	// ---------------- stage 4: round and sum ----------------
	logic            valid_s4, zero_s4;
	logic [3*FW-1:0] rgb_s4;
	logic [NW-1:0]   num_s4;
	logic [PW:0]     blend [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			blend[i] = {1'b0, pa_s3[i]} + {1'b0, pb_s3[i]} + (PW+1)'(32768);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else if (en)
			valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				rgb_s4[i*FW +: FW] <= zero_s3 ? FW'(CH_ONES) : FW'(blend[i] >> FW);
			zero_s4 <= zero_s3;
			num_s4  <= num_s3;
		end
	end

	// ---------------- divider stages: alpha quotient ----------------
	cil_pkg::div_stage_t div_q [NDS];
	cil_pkg::div_stage_t div_d [NDS];

	always_comb begin
		cil_pkg::div_stage_t src;
		logic [RW-1:0]       t;
		for (int k = 0; k < NDS; k++) begin
			if (k == 0) begin
				src.valid = valid_s4;
				src.zero  = zero_s4;
				src.rgb   = rgb_s4;
				src.rem   = '0;
				src.nq    = num_s4;
			end else begin
				src = div_q[k-1];
			end
			for (int s = 0; s < cil_pkg::DIV_STEPS; s++) begin
				t      = {src.rem[RW-2:0], src.nq[NW-1]};
				src.nq = {src.nq[NW-2:0], 1'b0};
				if (t >= RW'(cnt)) begin
					src.rem   = t - RW'(cnt);
					src.nq[0] = 1'b1;
				end else begin
					src.rem = t;
				end
			end
			div_d[k] = src;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NDS; k++)
				div_q[k] <= '0;
		end else if (en) begin
			for (int k = 0; k < NDS; k++)
				div_q[k] <= div_d[k];
		end
	end

	// ---------------- output register ----------------
	logic [NW:0]   alpha_sum;
	logic [FW-1:0] alpha_c;
	logic [FW-1:0] alpha_q;
	logic [3*FW-1:0] rgb_q;
	assign alpha_sum = {1'b0, div_q[NDS-1].nq} + (NW+1)'(cil_pkg::Q_TENTH);

	always_comb begin
		if (div_q[NDS-1].zero)
			alpha_c = '0;
		else if (opacity_mode_q == cil_pkg::OPA_HALF)
			alpha_c = cil_pkg::Q_HALF;
		else if (alpha_sum > (NW+1)'(16'hFFFF))
			alpha_c = 16'hFFFF;
		else
			alpha_c = alpha_sum[FW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= div_q[NDS-1].valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_q   <= div_q[NDS-1].rgb;
			alpha_q <= alpha_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {alpha_q, rgb_q};

`ifndef SYNTH
	// a waiting result must hold the whole pipe
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken while result stalled");

	// alpha is zero only for index zero, else at least the ramp floor
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[63:48] == '0) || (m_tdata[63:48] >= cil_pkg::Q_TENTH))
		else $error("alpha below ramp floor");

	// divider remainder stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		div_q[NDS-1].valid |-> (div_q[NDS-1].rem < RW'(cnt)))
		else $error("divider remainder out of range");

	// a lookup in stage 1 reaches stage 2 on the next enabled edge
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en) |=> valid_s2)
		else $error("lookup lost between stages");
`endif

endmodule
